// File: src/stirling_bell_number_engine_defines.svh
// ----------------------------------------------------------------------------
// stirling_bell_number_engine_defines
// assertion macros used by the engine's sequencer (sbn_seq)
// ----------------------------------------------------------------------------
`ifndef STIRLING_BELL_NUMBER_ENGINE_DEFINES_SVH
`define STIRLING_BELL_NUMBER_ENGINE_DEFINES_SVH

// same-cycle implication
`define SBN_ASSERT_IMP(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("sbn: same-cycle check failed");

// next-cycle implication
`define SBN_ASSERT_NXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("sbn: next-cycle check failed");

`endif

// File: src/sbn_pkg.sv
// ----------------------------------------------------------------------------
// sbn_pkg
// types, codes and microcode program of the stirling / bell number engine
// ----------------------------------------------------------------------------
package sbn_pkg;

    localparam int MAX_ROWS_DEF = 25;
    localparam int ROW_W        = 5;
    localparam int VAL_W        = 63;
    localparam int PC_W         = 4;
    localparam int COND_W       = 3;

    // step addresses
    localparam logic [PC_W-1:0] STEP_IDLE  = 4'd0;
    localparam logic [PC_W-1:0] STEP_CHECK = 4'd1;
    localparam logic [PC_W-1:0] STEP_ROW   = 4'd2;
    localparam logic [PC_W-1:0] STEP_LOAD  = 4'd3;
    localparam logic [PC_W-1:0] STEP_ELA   = 4'd4;
    localparam logic [PC_W-1:0] STEP_ELB   = 4'd5;
    localparam logic [PC_W-1:0] STEP_ONE   = 4'd6;
    localparam logic [PC_W-1:0] STEP_SRD   = 4'd7;
    localparam logic [PC_W-1:0] STEP_SACC  = 4'd8;
    localparam logic [PC_W-1:0] STEP_DONE  = 4'd9;

    // jump conditions
    localparam logic [COND_W-1:0] COND_NONE    = 3'd0;
    localparam logic [COND_W-1:0] COND_START   = 3'd1;
    localparam logic [COND_W-1:0] COND_BAD     = 3'd2;
    localparam logic [COND_W-1:0] COND_KLT2    = 3'd3;
    localparam logic [COND_W-1:0] COND_KGT2    = 3'd4;
    localparam logic [COND_W-1:0] COND_JLTN    = 3'd5;
    localparam logic [COND_W-1:0] COND_ILTN    = 3'd6;
    localparam logic [COND_W-1:0] COND_OUTFREE = 3'd7;

    // write address select
    localparam logic [1:0] WA_J   = 2'd0;
    localparam logic [1:0] WA_K   = 2'd1;
    localparam logic [1:0] WA_ONE = 2'd2;

    // read address select
    localparam logic [1:0] RA_JM1 = 2'd0;
    localparam logic [1:0] RA_KM1 = 2'd1;
    localparam logic [1:0] RA_I   = 2'd2;

    // write data select
    localparam logic WD_ONE = 1'b0;
    localparam logic WD_MAC = 1'b1;

    typedef struct packed {
        logic       we;
        logic [1:0] waddr_sel;
        logic       wdata_sel;
        logic       re;
        logic [1:0] raddr_sel;
        logic       k_load;
        logic       k_dec;
        logic       cur_load;
        logic       prod_load;
        logic       j_init;
        logic       j_inc;
        logic       i_init;
        logic       i_inc;
        logic       acc_clr;
        logic       acc_add;
    } dp_ctrl_t;

    typedef struct packed {
        logic [COND_W-1:0] cond;
        logic [PC_W-1:0]   target;
        logic              out_load;
        dp_ctrl_t          ops;
    } ucode_t;

    typedef struct packed {
        logic bad_row;
        logic k_lt2;
        logic k_gt2;
        logic j_lt_n;
        logic i_lt_n;
    } dp_stat_t;

    function automatic ucode_t ucode_rom(input logic [PC_W-1:0] pc);
        ucode_t w;
        w = '0;
        case (pc)
            STEP_IDLE: begin
                w.cond   = COND_START;
                w.target = STEP_CHECK;
            end
            STEP_CHECK: begin
                w.cond        = COND_BAD;
                w.target      = STEP_DONE;
                w.ops.j_init  = 1'b1;
                w.ops.acc_clr = 1'b1;
            end
            STEP_ROW: begin
                w.ops.we        = 1'b1;
                w.ops.waddr_sel = WA_J;
                w.ops.wdata_sel = WD_ONE;
                w.ops.re        = 1'b1;
                w.ops.raddr_sel = RA_JM1;
                w.ops.k_load    = 1'b1;
            end
            STEP_LOAD: begin
                w.cond         = COND_KLT2;
                w.target       = STEP_ONE;
                w.ops.cur_load = 1'b1;
            end
            STEP_ELA: begin
                w.ops.re        = 1'b1;
                w.ops.raddr_sel = RA_KM1;
                w.ops.prod_load = 1'b1;
            end
            STEP_ELB: begin
                w.cond          = COND_KGT2;
                w.target        = STEP_ELA;
                w.ops.we        = 1'b1;
                w.ops.waddr_sel = WA_K;
                w.ops.wdata_sel = WD_MAC;
                w.ops.cur_load  = 1'b1;
                w.ops.k_dec     = 1'b1;
            end
            STEP_ONE: begin
                w.cond          = COND_JLTN;
                w.target        = STEP_ROW;
                w.ops.we        = 1'b1;
                w.ops.waddr_sel = WA_ONE;
                w.ops.wdata_sel = WD_ONE;
                w.ops.j_inc     = 1'b1;
                w.ops.i_init    = 1'b1;
            end
            STEP_SRD: begin
                w.ops.re        = 1'b1;
                w.ops.raddr_sel = RA_I;
            end
            STEP_SACC: begin
                w.cond        = COND_ILTN;
                w.target      = STEP_SRD;
                w.ops.acc_add = 1'b1;
                w.ops.i_inc   = 1'b1;
            end
            STEP_DONE: begin
                w.cond     = COND_OUTFREE;
                w.target   = STEP_IDLE;
                w.out_load = 1'b1;
            end
            default: begin
                w.cond   = COND_NONE;
                w.target = STEP_IDLE;
            end
        endcase
        return w;
    endfunction

endpackage

// File: src/sbn_seq.sv
// ----------------------------------------------------------------------------
// sbn_seq
// step counter and microcode rom with conditional jumps
// ----------------------------------------------------------------------------
`include "stirling_bell_number_engine_defines.svh"

module sbn_seq (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             start,
    input  logic             out_free,
    input  sbn_pkg::dp_stat_t stat,
    output logic             in_ready,
    output logic             out_load,
    output sbn_pkg::dp_ctrl_t ctrl
);

    logic [sbn_pkg::PC_W-1:0] pc_reg;
    logic [sbn_pkg::PC_W-1:0] pc_next;
    sbn_pkg::ucode_t          uw;
    logic                     taken;
    logic                     wait_step;

    assign uw = sbn_pkg::ucode_rom(pc_reg);

    always_comb begin
        taken     = 1'b0;
        wait_step = 1'b0;
        case (uw.cond)
            sbn_pkg::COND_NONE:    taken = 1'b0;
            sbn_pkg::COND_START: begin
                taken     = start;
                wait_step = 1'b1;
            end
            sbn_pkg::COND_BAD:     taken = stat.bad_row;
            sbn_pkg::COND_KLT2:    taken = stat.k_lt2;
            sbn_pkg::COND_KGT2:    taken = stat.k_gt2;
            sbn_pkg::COND_JLTN:    taken = stat.j_lt_n;
            sbn_pkg::COND_ILTN:    taken = stat.i_lt_n;
            sbn_pkg::COND_OUTFREE: begin
                taken     = out_free;
                wait_step = 1'b1;
            end
            default:               taken = 1'b0;
        endcase
        if (taken) begin
            pc_next = uw.target;
        end else if (wait_step) begin
            pc_next = pc_reg;
        end else begin
            pc_next = pc_reg + 1'b1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            pc_reg <= sbn_pkg::STEP_IDLE;
        end else begin
            pc_reg <= pc_next;
        end
    end

    assign in_ready = (pc_reg == sbn_pkg::STEP_IDLE);
    assign out_load = uw.out_load & out_free;
    assign ctrl     = uw.ops;

    `SBN_ASSERT_NXT(a_idle_hold, aclk, aresetn, in_ready && !start, pc_reg == sbn_pkg::STEP_IDLE)
    `SBN_ASSERT_NXT(a_start_check, aclk, aresetn, start, pc_reg == sbn_pkg::STEP_CHECK)
    `SBN_ASSERT_NXT(a_done_stall, aclk, aresetn, pc_reg == sbn_pkg::STEP_DONE && !out_free, pc_reg == sbn_pkg::STEP_DONE)

endmodule

// File: src/sbn_dp.sv
// ----------------------------------------------------------------------------
// sbn_dp
// row store, shared multiply-add, counters and sum accumulator
// ----------------------------------------------------------------------------
module sbn_dp #(
    parameter int MAX_ROWS = sbn_pkg::MAX_ROWS_DEF
) (
    input  logic                      aclk,
    input  logic                      start,
    input  logic [sbn_pkg::ROW_W-1:0] row_in,
    input  logic [sbn_pkg::ROW_W-1:0] col_in,
    input  sbn_pkg::dp_ctrl_t         ctrl,
    output sbn_pkg::dp_stat_t         stat,
    output logic [sbn_pkg::VAL_W-1:0] stirling,
    output logic [sbn_pkg::VAL_W-1:0] bell,
    output logic                      err
);

    localparam int DEPTH = MAX_ROWS + 1;
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int RW    = sbn_pkg::ROW_W;
    localparam int VW    = sbn_pkg::VAL_W;

    logic [VW-1:0]    mem [DEPTH];
    logic [RW-1:0]    n_reg, col_reg, j_reg, k_reg, i_reg;
    logic [VW-1:0]    cur_reg, prod_reg, rd_reg, acc_reg, sv_reg;
    logic             err_reg;
    logic [RW-1:0]    waddr, raddr;
    logic [VW-1:0]    wdata;
    logic [VW+RW-1:0] prod_full;

    assign prod_full = {{VW{1'b0}}, k_reg} * {{RW{1'b0}}, cur_reg};

    always_comb begin
        case (ctrl.waddr_sel)
            sbn_pkg::WA_J:   waddr = j_reg;
            sbn_pkg::WA_K:   waddr = k_reg;
            sbn_pkg::WA_ONE: waddr = RW'(1);
            default:         waddr = j_reg;
        endcase
        case (ctrl.raddr_sel)
            sbn_pkg::RA_JM1: raddr = j_reg - 1'b1;
            sbn_pkg::RA_KM1: raddr = k_reg - 1'b1;
            sbn_pkg::RA_I:   raddr = i_reg;
            default:         raddr = i_reg;
        endcase
        if (ctrl.wdata_sel == sbn_pkg::WD_MAC) begin
            wdata = rd_reg + prod_reg;
        end else begin
            wdata = VW'(1);
        end
    end

    // row store
    always_ff @(posedge aclk) begin
        if (ctrl.we) begin
            mem[waddr[AW-1:0]] <= wdata;
        end
        if (ctrl.re) begin
            rd_reg <= mem[raddr[AW-1:0]];
        end
    end

    always_ff @(posedge aclk) begin
        if (start) begin
            n_reg   <= row_in;
            col_reg <= col_in;
            err_reg <= (row_in > RW'(MAX_ROWS));
        end
        if (ctrl.j_init) begin
            j_reg <= RW'(1);
        end else if (ctrl.j_inc) begin
            j_reg <= j_reg + 1'b1;
        end
        if (ctrl.k_load) begin
            k_reg <= j_reg - 1'b1;
        end else if (ctrl.k_dec) begin
            k_reg <= k_reg - 1'b1;
        end
        if (ctrl.i_init) begin
            i_reg <= RW'(1);
        end else if (ctrl.i_inc) begin
            i_reg <= i_reg + 1'b1;
        end
        if (ctrl.cur_load) begin
            cur_reg <= rd_reg;
        end
        if (ctrl.prod_load) begin
            prod_reg <= prod_full[VW-1:0];
        end
        if (ctrl.acc_clr) begin
            acc_reg <= '0;
            sv_reg  <= '0;
        end else if (ctrl.acc_add) begin
            acc_reg <= acc_reg + rd_reg;
            if (i_reg == col_reg) begin
                sv_reg <= rd_reg;
            end
        end
    end

    assign stat.bad_row = err_reg | (n_reg == '0);
    assign stat.k_lt2   = (k_reg < RW'(2));
    assign stat.k_gt2   = (k_reg > RW'(2));
    assign stat.j_lt_n  = (j_reg < n_reg);
    assign stat.i_lt_n  = (i_reg < n_reg);

    assign stirling = sv_reg;
    assign bell     = acc_reg;
    assign err      = err_reg;

endmodule

// File: src/stirling_bell_number_engine.sv
// ----------------------------------------------------------------------------
// stirling_bell_number_engine
// stirling numbers of the second kind and bell numbers per query
// ----------------------------------------------------------------------------
// usage:
//   s_ channel takes one query item: row n in s_tdata[4:0], column k in
//   s_tdata[9:5]. m_ channel returns one item per query: S(n,k) in
//   m_tdata[62:0], B(n) in m_tdata[125:63], m_tuser set when n > MAX_ROWS
//   (both values are then zero). row zero gives zeros without the flag.
//   the triangle is rebuilt for every query in a one-row store by a
//   microcoded sequencer driving one shared multiply-add.
//   the work for 1 <= n <= MAX_ROWS is set by the two-step multiply-add
//   loop over each row; rows that are zero or out of range skip the
//   triangle and go straight to the last step. one query is in work at a
//   time, so the next query can be taken in the cycle after the result
//   is loaded.
//   s_tready is high only while the sequencer waits for a query; the next
//   query may be taken while a result still sits in the output register.
//   a stalled receiver holds the result, and the engine waits at its last
//   step until the output register frees.
//   aresetn (synchronous) clears the sequencer and the output valid; the
//   row store needs no clearing.
// ----------------------------------------------------------------------------
module stirling_bell_number_engine #(
    parameter int MAX_ROWS = sbn_pkg::MAX_ROWS_DEF
) (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    output logic         s_tready,
    input  logic [15:0]  s_tdata,   // target_row, target_col
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [127:0] m_tdata,   // stirling_value, bell_value
    output logic         m_tuser    // range_error
);

    localparam int VW = sbn_pkg::VAL_W;
    localparam int RW = sbn_pkg::ROW_W;

    sbn_pkg::dp_ctrl_t ctrl;
    sbn_pkg::dp_stat_t stat;
    logic              in_ready;
    logic              accept;
    logic              out_free;
    logic              out_load;
    logic [VW-1:0]     stirling, bell;
    logic              err;

    logic              m_valid_reg, m_valid_next;
    logic [VW-1:0]     m_stir_reg, m_bell_reg;
    logic              m_err_reg;

    assign s_tready = in_ready;
    assign accept   = s_tvalid & in_ready;
    assign out_free = ~m_valid_reg | m_tready;

    sbn_seq u_seq (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .start    (accept),
        .out_free (out_free),
        .stat     (stat),
        .in_ready (in_ready),
        .out_load (out_load),
        .ctrl     (ctrl)
    );

    sbn_dp #(
        .MAX_ROWS (MAX_ROWS)
    ) u_dp (
        .aclk     (aclk),
        .start    (accept),
        .row_in   (s_tdata[RW-1:0]),
        .col_in   (s_tdata[2*RW-1:RW]),
        .ctrl     (ctrl),
        .stat     (stat),
        .stirling (stirling),
        .bell     (bell),
        .err      (err)
    );

    always_comb begin
        m_valid_next = m_valid_reg;
        if (out_load) begin
            m_valid_next = 1'b1;
        end else if (m_tready) begin
            m_valid_next = 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else begin
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (out_load) begin
            m_stir_reg <= stirling;
            m_bell_reg <= bell;
            m_err_reg  <= err;
        end
    end

    assign m_tvalid = m_valid_reg;
    assign m_tdata  = {2'b00, m_bell_reg, m_stir_reg};
    assign m_tuser  = m_err_reg;

endmodule

// File: verif/sbn_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// sbn_checker
// watches both stream channels of the stirling / bell number engine, works
// out S(n,k), B(n) and the range flag for every accepted query, and compares
// each returned item in order against the oldest outstanding prediction
// ----------------------------------------------------------------------------
module sbn_checker (
    input  logic         aclk,
    input  logic         aresetn,
    input  logic         s_tvalid,
    input  logic         s_tready,
    input  logic [15:0]  s_tdata,   // target_row, target_col
    input  logic         m_tvalid,
    input  logic         m_tready,
    input  logic [127:0] m_tdata,   // stirling_value, bell_value
    input  logic         m_tuser,   // range_error
    output int           fail_count,
    output int           pending
);

    localparam int ROW_LIMIT = sbn_pkg::MAX_ROWS_DEF;

    typedef struct {
        logic [sbn_pkg::VAL_W-1:0] stirling;
        logic [sbn_pkg::VAL_W-1:0] bell;
        logic                      range_error;
        logic [sbn_pkg::ROW_W-1:0] row;
        logic [sbn_pkg::ROW_W-1:0] col;
    } sbn_answer_t;

    sbn_answer_t answer_q[$];

    // rebuilds the triangle row by row in place, descending over k
    function automatic sbn_answer_t stirling_bell(input logic [sbn_pkg::ROW_W-1:0] row,
                                                  input logic [sbn_pkg::ROW_W-1:0] col);
        logic [sbn_pkg::VAL_W-1:0] tri_row [0:ROW_LIMIT];
        sbn_answer_t a;
        a.stirling    = '0;
        a.bell        = '0;
        a.range_error = 1'b0;
        a.row         = row;
        a.col         = col;
        if (int'(row) > ROW_LIMIT) begin
            a.range_error = 1'b1;
        end else if (row != 0) begin
            for (int j = 1; j <= int'(row); j++) begin
                for (int k = j; k >= 1; k--) begin
                    if (k == 1 || k == j) begin
                        tri_row[k] = sbn_pkg::VAL_W'(1);
                    end else begin
                        tri_row[k] = tri_row[k-1] + sbn_pkg::VAL_W'(k) * tri_row[k];
                    end
                end
            end
            for (int k = 1; k <= int'(row); k++) begin
                a.bell = a.bell + tri_row[k];
            end
            if (col >= 1 && col <= row) begin
                a.stirling = tri_row[col];
            end
        end
        return a;
    endfunction

    always @(posedge aclk) begin
        sbn_answer_t want;
        logic [sbn_pkg::VAL_W-1:0] got_s;
        logic [sbn_pkg::VAL_W-1:0] got_b;
        int errs;
        errs = 0;
        if (!aresetn) begin
            answer_q.delete();
            fail_count <= 0;
            pending    <= 0;
        end else begin
            if (m_tvalid && m_tready) begin
                got_s = m_tdata[62:0];
                got_b = m_tdata[125:63];
                if (answer_q.size() == 0) begin
                    errs = 1;
                    if (fail_count < 10) begin
                        $display("%0t: unexpected result item s=%0d b=%0d err=%0b",
                                 $realtime, got_s, got_b, m_tuser);
                    end
                end else begin
                    want = answer_q.pop_front();
                    if (got_s !== want.stirling || got_b !== want.bell
                            || m_tuser !== want.range_error) begin
                        errs = 1;
                        if (fail_count < 10) begin
                            $display("%0t: mismatch n=%0d k=%0d", $realtime, want.row, want.col);
                            $display("    expected s=%0d b=%0d err=%0b",
                                     want.stirling, want.bell, want.range_error);
                            $display("    actual   s=%0d b=%0d err=%0b", got_s, got_b, m_tuser);
                        end
                    end
                end
            end
            if (s_tvalid && s_tready) begin
                answer_q.push_back(stirling_bell(s_tdata[4:0], s_tdata[9:5]));
            end
            fail_count <= fail_count + errs;
            pending    <= answer_q.size();
        end
    end

endmodule

// File: verif/tb_stirling_bell_number_engine.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_stirling_bell_number_engine
// drives directed and random row / column queries into the engine with
// random gaps on the query side and random stalls on the result side; a
// separate checker predicts and compares every result item
// ----------------------------------------------------------------------------
module tb_stirling_bell_number_engine;

    localparam int NUM_ITEMS  = 1500;
    localparam int IDLE_LIMIT = 5000;
    localparam int TAIL       = 1000;

    logic         aclk;
    logic         aresetn;
    logic         s_tvalid;
    logic         s_tready;
    logic [15:0]  s_tdata;    // target_row, target_col
    logic         m_tvalid;
    logic         m_tready;
    logic [127:0] m_tdata;    // stirling_value, bell_value
    logic         m_tuser;    // range_error

    int fail_count;
    int pending;
    int idle_cycles;
    logic calm;

    stirling_bell_number_engine dut (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    sbn_checker u_checker (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser),
        .fail_count (fail_count),
        .pending    (pending)
    );

    initial aclk = 1'b0;
    always #5 aclk = ~aclk;

    // mostly short, a few long
    function automatic int gap_len();
        int r;
        r = $urandom_range(0, 99);
        if (calm || r < 55) begin
            return 0;
        end else if (r < 90) begin
            return $urandom_range(1, 4);
        end
        return $urandom_range(20, 80);
    endfunction

    task automatic send_query(input logic [4:0] row, input logic [4:0] col);
        int gap;
        gap = gap_len();
        if (gap > 0) begin
            s_tvalid = 1'b0;
            repeat (gap) @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = {6'd0, col, row};
        do @(posedge aclk); while (!s_tready);
        @(negedge aclk);
    endtask

    // result side stalls
    initial begin
        int stall;
        stall    = 0;
        m_tready = 1'b0;
        forever begin
            @(negedge aclk);
            if (stall > 0) begin
                m_tready = 1'b0;
                stall--;
            end else begin
                m_tready = 1'b1;
                if (!calm && $urandom_range(0, 5) == 0) begin
                    stall = gap_len() + 1;
                end
            end
        end
    end

    // watchdog on cycles with no accepted item
    always @(posedge aclk) begin
        if (!aresetn || (s_tvalid && s_tready) || (m_tvalid && m_tready)) begin
            idle_cycles <= 0;
        end else begin
            idle_cycles <= idle_cycles + 1;
            if (idle_cycles >= IDLE_LIMIT) begin
                $display("TEST FAILED");
                $finish;
            end
        end
    end

    initial begin
        logic [4:0] row;
        logic [4:0] col;
        int sel;
        aresetn     = 1'b0;
        s_tvalid    = 1'b0;
        s_tdata     = '0;
        calm        = 1'b0;
        repeat (6) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // directed: zero row, tiny rows, column zero and beyond the row,
        // largest legal row, rows out of range, all-ones fields
        send_query(5'd0, 5'd0);
        send_query(5'd0, 5'd3);
        send_query(5'd1, 5'd1);
        send_query(5'd1, 5'd0);
        send_query(5'd2, 5'd2);
        send_query(5'd3, 5'd2);
        send_query(5'd5, 5'd0);
        send_query(5'd5, 5'd6);
        send_query(5'd5, 5'd3);
        send_query(5'd10, 5'd31);
        send_query(5'd24, 5'd12);
        send_query(5'd25, 5'd1);
        send_query(5'd25, 5'd12);
        send_query(5'd25, 5'd13);
        send_query(5'd25, 5'd25);
        send_query(5'd25, 5'd26);
        send_query(5'd25, 5'd0);
        send_query(5'd26, 5'd1);
        send_query(5'd31, 5'd31);
        send_query(5'd30, 5'd21);
        send_query(5'd21, 5'd10);

        for (int i = 0; i < NUM_ITEMS; i++) begin
            if (i % 100 == 0) begin
                calm = ($urandom_range(0, 4) == 0);
            end
            sel = $urandom_range(0, 99);
            if (sel < 8) begin
                row = 5'd0;
            end else if (sel < 22) begin
                row = 5'($urandom_range(26, 31));
            end else if (sel < 40) begin
                row = 5'($urandom_range(18, 25));
            end else begin
                row = 5'($urandom_range(1, 17));
            end
            sel = $urandom_range(0, 9);
            if (sel == 0 || row == 0 || row > 5'd25) begin
                col = 5'($urandom_range(0, 31));
            end else if (sel == 1) begin
                col = 5'd0;
            end else if (sel == 2) begin
                col = row + 5'd1;
            end else begin
                col = 5'($urandom_range(1, row));
            end
            send_query(row, col);
        end
        s_tvalid = 1'b0;

        while (pending != 0 || (s_tvalid && s_tready)) @(posedge aclk);
        repeat (TAIL) @(posedge aclk);
        if (fail_count == 0) begin
            $display("TEST PASSED");
        end else begin
            $display("TEST FAILED");
        end
        $finish;
    end

endmodule

// File: files.f
+incdir+src
src/sbn_pkg.sv
src/sbn_seq.sv
src/sbn_dp.sv
src/stirling_bell_number_engine.sv
verif/sbn_checker.sv
verif/tb_stirling_bell_number_engine.sv
